FILE: sv/ip_address_text_classifier_macros.svh
// ----------------------------------------------------------------------------
// ip_address_text_classifier_macros
// assertion macros used by the classifier back end (iptc_back)
// ----------------------------------------------------------------------------
`ifndef IP_ADDRESS_TEXT_CLASSIFIER_MACROS_SVH
`define IP_ADDRESS_TEXT_CLASSIFIER_MACROS_SVH

// property holds at every clock once out of reset
`define IPTC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define IPTC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define IPTC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/iptc_pkg.sv
// ----------------------------------------------------------------------------
// iptc_pkg
// types and constants of the address text classifier
// ----------------------------------------------------------------------------
`default_nettype none

package iptc_pkg;

    typedef enum logic [1:0] {
        VERDICT_IPV4    = 2'd0,
        VERDICT_IPV6    = 2'd1,
        VERDICT_NEITHER = 2'd2
    } verdict_t;

    // one classified word between front and back
    typedef struct packed {
        logic       eol;
        logic       is_digit;
        logic       is_hex;
        logic       is_dot;
        logic       is_colon;
        logic [3:0] digit;
    } char_word_t;

    localparam logic [7:0]  CHAR_DOT   = 8'h2E;
    localparam logic [7:0]  CHAR_COLON = 8'h3A;
    localparam logic [7:0]  CHAR_ZERO  = 8'h30;

    localparam logic [11:0] OCTET_MAX         = 12'd255;
    localparam logic [1:0]  DOTTED_DIGITS_MAX = 2'd3;
    localparam logic [1:0]  DOTTED_BLOCKS_MAX = 2'd3;
    localparam logic [2:0]  COLON_DIGITS_MAX  = 3'd4;
    localparam logic [2:0]  COLON_BLOCKS_MAX  = 3'd7;

    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_DEPTH = 2 ** QUEUE_AW;

endpackage

`default_nettype wire

FILE: sv/ip_address_text_classifier.sv
// ----------------------------------------------------------------------------
// ip_address_text_classifier
// classifies a text line as dotted ipv4, colon ipv6 or neither
//
// channel  direction  handshake             payload
// in       sink       in_valid / in_ready   op, character
// out      source     out_valid / out_ready verdict
//
// one word accepted per cycle while the out channel is not stalled, characters and end of line alike
// an end-of-line word passes the front register and a queue slot, then its verdict
// is registered in the verdict register
// a stalled out channel holds only end-of-line words; characters ahead of a held one still drain
// through the two-entry queue into the recognisers
// reset clears the recognisers, the queue and both valid flags at once
// ----------------------------------------------------------------------------
`default_nettype none

module ip_address_text_classifier (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       op,
    input  wire logic [7:0] character,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      verdict
);
    import iptc_pkg::*;

    logic       front_valid;
    logic       front_ready;
    char_word_t front_word;
    logic       queue_valid;
    logic       queue_ready;
    char_word_t queue_word;

    iptc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .character  (character),
        .word_valid (front_valid),
        .word_ready (front_ready),
        .word       (front_word)
    );

    iptc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_word  (front_word),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_word   (queue_word)
    );

    iptc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (queue_valid),
        .word_ready (queue_ready),
        .word       (queue_word),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .verdict    (verdict)
    );

endmodule

`default_nettype wire

FILE: sv/iptc_front.sv
// ----------------------------------------------------------------------------
// iptc_front
// accepts input words and registers their character class
// ----------------------------------------------------------------------------
`default_nettype none

module iptc_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               op,
    input  wire logic [7:0]         character,
    output logic                    word_valid,
    input  wire logic               word_ready,
    output iptc_pkg::char_word_t    word
);
    import iptc_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    char_word_t word_reg;
    char_word_t word_next;
    logic       accept;

    assign in_ready = !valid_reg || word_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        word_next          = '0;
        word_next.eol      = op;
        word_next.is_digit = !op && (character inside {[8'h30:8'h39]});
        word_next.is_hex   = !op && (character inside {[8'h30:8'h39], [8'h41:8'h46],
                                                       [8'h61:8'h66]});
        word_next.is_dot   = !op && (character == CHAR_DOT);
        word_next.is_colon = !op && (character == CHAR_COLON);
        word_next.digit    = 4'(character - CHAR_ZERO);
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (word_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg <= word_next;
        end
    end

    assign word_valid = valid_reg;
    assign word       = word_reg;

endmodule

`default_nettype wire

FILE: sv/iptc_queue.sv
// ----------------------------------------------------------------------------
// iptc_queue
// short fifo of classified words between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module iptc_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push_valid,
    output logic                    push_ready,
    input  wire iptc_pkg::char_word_t push_word,
    output logic                    pop_valid,
    input  wire logic               pop_ready,
    output iptc_pkg::char_word_t    pop_word
);
    import iptc_pkg::*;

    char_word_t          mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg;
    logic [QUEUE_AW:0]   count_next;
    logic                push;
    logic                pop;

    assign push_ready = (count_reg != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_word   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

`default_nettype wire

FILE: sv/iptc_back.sv
// ----------------------------------------------------------------------------
// iptc_back
// dotted and colon recognisers and the verdict output register
// ----------------------------------------------------------------------------
`default_nettype none

`include "ip_address_text_classifier_macros.svh"

module iptc_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               word_valid,
    output logic                    word_ready,
    input  wire iptc_pkg::char_word_t word,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [1:0]              verdict
);
    import iptc_pkg::*;

    logic       dotted_ok_reg;
    logic       dotted_ok_next;
    logic [1:0] dotted_blocks_reg;
    logic [1:0] dotted_blocks_next;
    logic [1:0] dotted_digits_reg;
    logic [1:0] dotted_digits_next;
    logic [7:0] dotted_value_reg;
    logic [7:0] dotted_value_next;
    logic       dotted_zero_reg;
    logic       dotted_zero_next;
    logic       colon_ok_reg;
    logic       colon_ok_next;
    logic [2:0] colon_blocks_reg;
    logic [2:0] colon_blocks_next;
    logic [2:0] colon_digits_reg;
    logic [2:0] colon_digits_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    verdict_t   verdict_reg;
    verdict_t   verdict_next;
    logic [11:0] dotted_sum;
    logic       pop;
    logic       recog_clear;
    logic       lone_zero;

    assign word_ready = !word.eol || !out_valid_reg || out_ready;
    assign pop        = word_valid && word_ready;
    assign dotted_sum = {1'b0, dotted_value_reg, 3'b000} + {3'b000, dotted_value_reg, 1'b0}
                      + {8'd0, word.digit};

    assign recog_clear = dotted_ok_reg && colon_ok_reg
                       && dotted_blocks_reg == '0 && colon_blocks_reg == '0
                       && dotted_digits_reg == '0 && colon_digits_reg == '0;
    assign lone_zero   = dotted_digits_reg == 2'd1 && dotted_value_reg == '0;

    always_comb
    begin
        dotted_ok_next     = dotted_ok_reg;
        dotted_blocks_next = dotted_blocks_reg;
        dotted_digits_next = dotted_digits_reg;
        dotted_value_next  = dotted_value_reg;
        dotted_zero_next   = dotted_zero_reg;
        colon_ok_next      = colon_ok_reg;
        colon_blocks_next  = colon_blocks_reg;
        colon_digits_next  = colon_digits_reg;
        verdict_next       = verdict_reg;
        out_valid_next     = out_ready ? 1'b0 : out_valid_reg;

        if (pop && word.eol)
        begin
            if (dotted_ok_reg && dotted_blocks_reg == DOTTED_BLOCKS_MAX
                && dotted_digits_reg != '0)
            begin
                verdict_next = VERDICT_IPV4;
            end
            else if (colon_ok_reg && colon_blocks_reg == COLON_BLOCKS_MAX
                     && colon_digits_reg != '0)
            begin
                verdict_next = VERDICT_IPV6;
            end
            else
            begin
                verdict_next = VERDICT_NEITHER;
            end
            out_valid_next     = 1'b1;
            dotted_ok_next     = 1'b1;
            dotted_blocks_next = '0;
            dotted_digits_next = '0;
            dotted_value_next  = '0;
            dotted_zero_next   = 1'b0;
            colon_ok_next      = 1'b1;
            colon_blocks_next  = '0;
            colon_digits_next  = '0;
        end
        else if (pop)
        begin
            // dotted form
            if (dotted_ok_reg)
            begin
                if (word.is_digit)
                begin
                    if (dotted_digits_reg == DOTTED_DIGITS_MAX
                        || (dotted_digits_reg == 2'd1 && dotted_zero_reg)
                        || dotted_sum > OCTET_MAX)
                    begin
                        dotted_ok_next = 1'b0;
                    end
                    else
                    begin
                        if (dotted_digits_reg == '0)
                        begin
                            dotted_zero_next = (word.digit == 4'd0);
                        end
                        dotted_value_next  = dotted_sum[7:0];
                        dotted_digits_next = dotted_digits_reg + 1'b1;
                    end
                end
                else if (word.is_dot)
                begin
                    if (dotted_digits_reg == '0 || dotted_blocks_reg == DOTTED_BLOCKS_MAX)
                    begin
                        dotted_ok_next = 1'b0;
                    end
                    else
                    begin
                        dotted_blocks_next = dotted_blocks_reg + 1'b1;
                        dotted_digits_next = '0;
                        dotted_value_next  = '0;
                        dotted_zero_next   = 1'b0;
                    end
                end
                else
                begin
                    dotted_ok_next = 1'b0;
                end
            end
            // colon form
            if (colon_ok_reg)
            begin
                if (word.is_hex)
                begin
                    if (colon_digits_reg == COLON_DIGITS_MAX)
                    begin
                        colon_ok_next = 1'b0;
                    end
                    else
                    begin
                        colon_digits_next = colon_digits_reg + 1'b1;
                    end
                end
                else if (word.is_colon)
                begin
                    if (colon_digits_reg == '0 || colon_blocks_reg == COLON_BLOCKS_MAX)
                    begin
                        colon_ok_next = 1'b0;
                    end
                    else
                    begin
                        colon_blocks_next = colon_blocks_reg + 1'b1;
                        colon_digits_next = '0;
                    end
                end
                else
                begin
                    colon_ok_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dotted_ok_reg     <= 1'b1;
            dotted_blocks_reg <= '0;
            dotted_digits_reg <= '0;
            dotted_value_reg  <= '0;
            dotted_zero_reg   <= 1'b0;
            colon_ok_reg      <= 1'b1;
            colon_blocks_reg  <= '0;
            colon_digits_reg  <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            dotted_ok_reg     <= dotted_ok_next;
            dotted_blocks_reg <= dotted_blocks_next;
            dotted_digits_reg <= dotted_digits_next;
            dotted_value_reg  <= dotted_value_next;
            dotted_zero_reg   <= dotted_zero_next;
            colon_ok_reg      <= colon_ok_next;
            colon_blocks_reg  <= colon_blocks_next;
            colon_digits_reg  <= colon_digits_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        verdict_reg <= verdict_next;
    end

    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;

    `IPTC_ASSERT_NEXT(a_clear_after_eol, pop && word.eol, recog_clear, "recognisers not cleared")
    `IPTC_ASSERT_IMPL(a_zero_block, dotted_zero_reg, lone_zero, "leading zero flag out of step")
    `IPTC_ASSERT(a_colon_digits, colon_digits_reg <= COLON_DIGITS_MAX, "colon block too long")

endmodule

`default_nettype wire
